### rtl/core/assert_macros.svh
// Assertion macros for the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge outside reset.
`define CHK_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define CHK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/mcd_pkg.sv
package mcd_pkg;

  localparam int unsigned SCAN_LIMIT   = 4096;
  localparam int unsigned PHASE_PERIOD = 42;
  localparam int unsigned SCAN_W       = $clog2(SCAN_LIMIT + 1);
  localparam int unsigned PHASE_W      = 6;
  localparam int unsigned DIST_W       = 9;

  localparam logic [31:0] CRC_POLY   = 32'h82F6_3B78;
  localparam logic [31:0] CRC_PRESET = 32'hFFFF_FFFF;
  localparam logic [15:0] AVG_RESET  = 16'h8000;
  localparam logic [15:0] FULL16     = 16'hFFFF;

  typedef struct packed {
    logic take;
    logic blend;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_sts_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] acc_in, input logic [7:0] b);
    logic [31:0] acc;
    acc = acc_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      acc = acc[0] ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
    end
    return acc;
  endfunction

  // 0.75 * old + 0.25 * new in the 16-bit fixed-point form, truncated.
  function automatic logic [15:0] blend(input logic [15:0] prev, input logic [15:0] sample);
    logic [17:0] sum;
    sum = ({2'd0, prev} << 1) + {2'd0, prev} + {2'd0, sample};
    return sum[17:2];
  endfunction

endpackage

### rtl/core/mcd_ctrl.sv
module mcd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_last_byte,
  output logic              in_stall,
  input  mcd_pkg::dp_sts_t  sts,
  output mcd_pkg::dp_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_BLEND,
    S_FINISH
  } state_t;

  state_t state_r;
  logic   in_stall_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_stall_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid && in_last_byte) begin
            state_r    <= S_BLEND;
            in_stall_r <= 1'b1;
          end
        end
        S_BLEND: begin
          state_r <= S_FINISH;
        end
        S_FINISH: begin
          if (sts.out_free) begin
            state_r    <= S_IDLE;
            in_stall_r <= 1'b0;
          end
        end
        default: begin
          state_r    <= S_IDLE;
          in_stall_r <= 1'b0;
        end
      endcase
    end
  end

  assign in_stall = in_stall_r;

  always_comb begin
    cmd.take   = (state_r == S_IDLE) && in_valid;
    cmd.blend  = (state_r == S_BLEND);
    cmd.finish = (state_r == S_FINISH) && sts.out_free;
  end

endmodule

### rtl/core/mcd_dp.sv
module mcd_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  mcd_pkg::dp_cmd_t  cmd,
  input  logic [7:0]        in_data_byte,
  output mcd_pkg::dp_sts_t  sts,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [31:0]       out_message_crc,
  output logic [15:0]       out_phi_value,
  output logic [5:0]        out_phase_count,
  output logic [31:0]       out_message_count
);

  logic [31:0]                  crc_r, crc_nxt;
  logic [255:0]                 seen_r, seen_nxt;
  logic [mcd_pkg::DIST_W-1:0]   distinct_r, distinct_nxt;
  logic [mcd_pkg::SCAN_W-1:0]   scanned_r, scanned_nxt;
  logic [15:0]                  coh_r, coh_nxt;
  logic [15:0]                  div_r, div_nxt;
  logic [mcd_pkg::PHASE_W-1:0]  phase_r, phase_nxt;
  logic [31:0]                  count_r, count_nxt;
  logic [31:0]                  crc_hold_r;
  logic                         out_valid_r;
  logic [31:0]                  out_crc_r;
  logic [15:0]                  out_phi_r;
  logic [mcd_pkg::PHASE_W-1:0]  out_phase_r;
  logic [31:0]                  out_count_r;

  logic [31:0]                  final_crc;
  logic [24:0]                  div_scaled;
  logic [15:0]                  div_sample;
  logic [15:0]                  div_inv;
  logic [31:0]                  phi_prod;
  logic [mcd_pkg::PHASE_W:0]    phase_inc;

  assign final_crc  = ~crc_r;
  assign div_scaled = ({distinct_r, 16'd0}) - {16'd0, distinct_r};
  assign div_sample = div_scaled[23:8];
  assign div_inv    = mcd_pkg::FULL16 - div_r;
  assign phi_prod   = {16'd0, div_inv} * {16'd0, coh_r};
  assign phase_inc  = {1'b0, phase_r} + 1'b1;

  always_comb begin
    crc_nxt      = crc_r;
    seen_nxt     = seen_r;
    distinct_nxt = distinct_r;
    scanned_nxt  = scanned_r;
    coh_nxt      = coh_r;
    div_nxt      = div_r;
    phase_nxt    = phase_r;
    count_nxt    = count_r;
    if (cmd.take) begin
      crc_nxt = mcd_pkg::crc_byte(crc_r, in_data_byte);
      if (scanned_r < mcd_pkg::SCAN_W'(mcd_pkg::SCAN_LIMIT)) begin
        if (!seen_r[in_data_byte]) begin
          seen_nxt[in_data_byte] = 1'b1;
          distinct_nxt           = distinct_r + 1'b1;
        end
        scanned_nxt = scanned_r + 1'b1;
      end
    end
    if (cmd.blend) begin
      coh_nxt      = mcd_pkg::blend(coh_r, final_crc[15:0]);
      div_nxt      = mcd_pkg::blend(div_r, div_sample);
      crc_nxt      = mcd_pkg::CRC_PRESET;
      seen_nxt     = '0;
      distinct_nxt = '0;
      scanned_nxt  = '0;
    end
    if (cmd.finish) begin
      phase_nxt = (phase_inc >= (mcd_pkg::PHASE_W + 1)'(mcd_pkg::PHASE_PERIOD)) ?
                  '0 : phase_inc[mcd_pkg::PHASE_W-1:0];
      count_nxt = count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r       <= mcd_pkg::CRC_PRESET;
      seen_r      <= '0;
      distinct_r  <= '0;
      scanned_r   <= '0;
      coh_r       <= mcd_pkg::AVG_RESET;
      div_r       <= mcd_pkg::AVG_RESET;
      phase_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      crc_r      <= crc_nxt;
      seen_r     <= seen_nxt;
      distinct_r <= distinct_nxt;
      scanned_r  <= scanned_nxt;
      coh_r      <= coh_nxt;
      div_r      <= div_nxt;
      phase_r    <= phase_nxt;
      count_r    <= count_nxt;
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.blend) begin
      crc_hold_r <= final_crc;
    end
    if (cmd.finish) begin
      out_crc_r   <= crc_hold_r;
      out_phi_r   <= phi_prod[31:16];
      out_phase_r <= phase_nxt;
      out_count_r <= count_nxt;
    end
  end

  assign sts.out_free      = !out_valid_r || !out_stall;
  assign out_valid         = out_valid_r;
  assign out_message_crc   = out_crc_r;
  assign out_phi_value     = out_phi_r;
  assign out_phase_count   = out_phase_r;
  assign out_message_count = out_count_r;

endmodule

### rtl/core/message_crc_diversity_ema_tracker.sv
// Message CRC32C and byte-diversity tracker.
// The input channel carries one message byte per transfer, with in_last_byte
// set on the final byte. Bytes are taken one per cycle unless the input stalls.
// Each byte updates a reflected CRC32C and, over the first 4096 bytes, a map of
// the byte values seen, which gives a count of distinct values.
// After the transfer of a marked byte the input stalls: the blend state updates
// the CRC and diversity averages, then the finish state forms phi in a 16 by 16
// multiplier and loads the output register, which offers the result. The input
// stays stalled until the finish state has loaded that register.
// The result waits in its output register while the receiver stalls; bytes of
// the next message are taken meanwhile, and the block holds only at the end of
// that message until the waiting result has been transferred.
// Reset sets the CRC to all ones, clears the seen map, the counts and the phase,
// and sets both averages to one half.
module message_crc_diversity_ema_tracker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_message_crc,
  output logic [15:0] out_phi_value,
  output logic [5:0]  out_phase_count,
  output logic [31:0] out_message_count
);

  mcd_pkg::dp_cmd_t cmd;
  mcd_pkg::dp_sts_t sts;

  mcd_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_last_byte (in_last_byte),
    .in_stall     (in_stall),
    .sts          (sts),
    .cmd          (cmd)
  );

  mcd_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_data_byte      (in_data_byte),
    .sts               (sts),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_message_crc   (out_message_crc),
    .out_phi_value     (out_phi_value),
    .out_phase_count   (out_phase_count),
    .out_message_count (out_message_count)
  );

endmodule

### rtl/core/mcd_checker.sv
`include "assert_macros.svh"

module mcd_props (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_last_byte,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_message_crc,
  input logic [5:0]  out_phase_count,
  input logic [31:0] out_message_count
);

  `CHK_NEXT(a_out_hold, out_valid && out_stall, out_valid, "Stalled result was dropped.")
  `CHK_NEXT(a_out_stable, out_valid && out_stall, $stable(out_message_crc) && $stable(out_message_count), "Stalled result changed.")
  `CHK_NEXT(a_last_stalls, in_valid && !in_stall && in_last_byte, in_stall, "Input not held after the final byte.")
  `CHK_IMPLY(a_phase_range, out_valid, out_phase_count < 6'(mcd_pkg::PHASE_PERIOD), "Phase out of range.")
  `CHK_IMPLY(a_rise_after_stall, $rose(out_valid), $past(in_stall), "Result appeared without end-of-message work.")

endmodule

bind message_crc_diversity_ema_tracker mcd_props u_mcd_props (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .in_last_byte      (in_last_byte),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_message_crc   (out_message_crc),
  .out_phase_count   (out_phase_count),
  .out_message_count (out_message_count)
);
